>>> src/modular_inverse_euclid_unit_defines.svh
// Assertion macros shared by the modular inverse unit files.
`ifndef MODULAR_INVERSE_EUCLID_UNIT_DEFINES_SVH
`define MODULAR_INVERSE_EUCLID_UNIT_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define MIE_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("modular inverse unit: assertion failed");

// Next-cycle implication, checked out of reset.
`define MIE_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("modular inverse unit: assertion failed");

`endif

>>> src/mie_pkg.sv
// Package for the modular inverse unit: widths, microcode codes and control program.
package mie_pkg;

    localparam int DATA_WIDTH = 32;
    // coefficient width: Bezout coefficients and partial products stay within DATA_WIDTH + 3 bits
    localparam int S_WIDTH    = DATA_WIDTH + 3;
    localparam int CNT_W      = $clog2(DATA_WIDTH);
    localparam int PC_W       = 4;

    // datapath operations
    localparam logic [2:0] OP_NOP       = 3'd0;
    localparam logic [2:0] OP_LOAD      = 3'd1;
    localparam logic [2:0] OP_DIV       = 3'd2;
    localparam logic [2:0] OP_RUPD      = 3'd3;
    localparam logic [2:0] OP_SUPD      = 3'd4;
    localparam logic [2:0] OP_EMIT_OK   = 3'd5;
    localparam logic [2:0] OP_EMIT_FAIL = 3'd6;

    // jump conditions
    localparam logic [2:0] C_NEVER        = 3'd0;
    localparam logic [2:0] C_ALWAYS       = 3'd1;
    localparam logic [2:0] C_NO_INPUT     = 3'd2;
    localparam logic [2:0] C_B_ZERO       = 3'd3;
    localparam logic [2:0] C_NOT_CNT_LAST = 3'd4;
    localparam logic [2:0] C_RC_ZERO      = 3'd5;
    localparam logic [2:0] C_NOT_RP_ONE   = 3'd6;
    localparam logic [2:0] C_OUT_BUSY     = 3'd7;

    // program steps
    localparam logic [PC_W-1:0] P_WAIT = 4'd0;
    localparam logic [PC_W-1:0] P_CHKZ = 4'd1;
    localparam logic [PC_W-1:0] P_DIV  = 4'd2;
    localparam logic [PC_W-1:0] P_RUPD = 4'd3;
    localparam logic [PC_W-1:0] P_TEST = 4'd4;
    localparam logic [PC_W-1:0] P_SUPD = 4'd5;
    localparam logic [PC_W-1:0] P_FIN  = 4'd6;
    localparam logic [PC_W-1:0] P_OK   = 4'd7;
    localparam logic [PC_W-1:0] P_FAIL = 4'd8;

    typedef struct packed {
        logic [2:0]      op;
        logic [2:0]      cond;
        logic [PC_W-1:0] jump;
        logic [PC_W-1:0] next;
    } t_ctrl;

    typedef struct packed {
        logic in_valid;
        logic b_zero;
        logic cnt_last;
        logic rc_zero;
        logic rp_one;
        logic out_busy;
    } t_stat;

    // control store: one word per step
    function automatic t_ctrl ucode(input logic [PC_W-1:0] pc);
        t_ctrl w;
        unique case (pc)
            P_WAIT:  w = '{OP_LOAD,      C_NO_INPUT,     P_WAIT, P_CHKZ};
            P_CHKZ:  w = '{OP_NOP,       C_B_ZERO,       P_FAIL, P_DIV};
            P_DIV:   w = '{OP_DIV,       C_NOT_CNT_LAST, P_DIV,  P_RUPD};
            P_RUPD:  w = '{OP_RUPD,      C_NEVER,        P_WAIT, P_TEST};
            P_TEST:  w = '{OP_NOP,       C_RC_ZERO,      P_FIN,  P_SUPD};
            P_SUPD:  w = '{OP_SUPD,      C_ALWAYS,       P_DIV,  P_DIV};
            P_FIN:   w = '{OP_NOP,       C_NOT_RP_ONE,   P_FAIL, P_OK};
            P_OK:    w = '{OP_EMIT_OK,   C_OUT_BUSY,     P_OK,   P_WAIT};
            P_FAIL:  w = '{OP_EMIT_FAIL, C_OUT_BUSY,     P_FAIL, P_WAIT};
            default: w = '{OP_NOP,       C_ALWAYS,       P_WAIT, P_WAIT};
        endcase
        return w;
    endfunction

endpackage

>>> src/mie_seq.sv
// Microcode sequencer: step counter, control store and conditional jumps.
module mie_seq (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  mie_pkg::t_stat i_stat,
    output mie_pkg::t_ctrl o_ctrl
);
    import mie_pkg::*;

    logic [PC_W-1:0] r_pc;
    logic [PC_W-1:0] n_pc;
    t_ctrl           ctrl;
    logic            take;

    assign ctrl   = ucode(r_pc);
    assign o_ctrl = ctrl;

    always_comb begin
        unique case (ctrl.cond)
            C_NEVER:        take = 1'b0;
            C_ALWAYS:       take = 1'b1;
            C_NO_INPUT:     take = !i_stat.in_valid;
            C_B_ZERO:       take = i_stat.b_zero;
            C_NOT_CNT_LAST: take = !i_stat.cnt_last;
            C_RC_ZERO:      take = i_stat.rc_zero;
            C_NOT_RP_ONE:   take = !i_stat.rp_one;
            C_OUT_BUSY:     take = i_stat.out_busy;
            default:        take = 1'b1;
        endcase
        n_pc = take ? ctrl.jump : ctrl.next;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= P_WAIT;
        end else begin
            r_pc <= n_pc;
        end
    end

endmodule

>>> src/mie_datapath.sv
// Datapath: bit-serial divider, coefficient accumulator and output register.
`include "modular_inverse_euclid_unit_defines.svh"

module mie_datapath (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  mie_pkg::t_ctrl                      i_ctrl,
    input  logic                                i_valid,
    input  logic signed [mie_pkg::DATA_WIDTH-1:0] i_value,
    input  logic signed [mie_pkg::DATA_WIDTH-1:0] i_modulus,
    input  logic                                i_stall,
    output mie_pkg::t_stat                      o_stat,
    output logic                                o_valid,
    output logic        [mie_pkg::DATA_WIDTH-2:0] o_inverse,
    output logic                                o_has_inverse
);
    import mie_pkg::*;

    // division registers: dividend shifts out, remainder builds up
    logic [DATA_WIDTH-1:0] r_num, r_den, r_rem, r_b;
    logic [DATA_WIDTH-1:0] r_rp, r_rc;
    logic [S_WIDTH-1:0]    r_sp, r_sc, r_prod;
    logic [CNT_W-1:0]      r_cnt;
    logic                  r_out_valid, r_has;
    logic [DATA_WIDTH-2:0] r_inverse;

    logic [DATA_WIDTH-1:0] mag_a, mag_b;
    logic [DATA_WIDTH:0]   trial;
    logic [DATA_WIDTH+1:0] diff;
    logic                  qbit;
    logic [DATA_WIDTH-1:0] rem_next;
    logic [S_WIDTH-1:0]    inv_full;
    logic                  sc_pos;
    logic                  out_busy, emit;

    assign mag_a = i_value[DATA_WIDTH-1]   ? DATA_WIDTH'(-i_value)   : DATA_WIDTH'(i_value);
    assign mag_b = i_modulus[DATA_WIDTH-1] ? DATA_WIDTH'(-i_modulus) : DATA_WIDTH'(i_modulus);

    assign trial    = {r_rem, r_num[DATA_WIDTH-1]};
    assign diff     = {1'b0, trial} - {2'b00, r_den};
    assign qbit     = !diff[DATA_WIDTH+1];
    assign rem_next = qbit ? diff[DATA_WIDTH-1:0] : trial[DATA_WIDTH-1:0];

    assign sc_pos   = !r_sc[S_WIDTH-1] && (r_sc != '0);
    assign inv_full = sc_pos ? r_sc : r_sc + {{(S_WIDTH-DATA_WIDTH){1'b0}}, r_b};

    assign out_busy = r_out_valid && i_stall;
    assign emit     = (i_ctrl.op == OP_EMIT_OK || i_ctrl.op == OP_EMIT_FAIL) && !out_busy;

    always_comb begin
        o_stat.in_valid = i_valid;
        o_stat.b_zero   = (r_b == '0);
        o_stat.cnt_last = (r_cnt == CNT_W'(DATA_WIDTH-1));
        o_stat.rc_zero  = (r_rc == '0);
        o_stat.rp_one   = (r_rp == DATA_WIDTH'(1));
        o_stat.out_busy = out_busy;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            case (i_ctrl.op)
                OP_LOAD: begin
                    r_num  <= mag_a;
                    r_den  <= mag_b;
                    r_b    <= mag_b;
                    r_rem  <= '0;
                    r_prod <= '0;
                    r_cnt  <= '0;
                    r_sp   <= S_WIDTH'(1);
                    r_sc   <= '0;
                end
                OP_DIV: begin
                    r_num  <= {r_num[DATA_WIDTH-2:0], qbit};
                    r_rem  <= rem_next;
                    // Horner accumulation of quotient times current coefficient
                    r_prod <= {r_prod[S_WIDTH-2:0], 1'b0} + (qbit ? r_sc : '0);
                    r_cnt  <= r_cnt + 1'b1;
                end
                OP_RUPD: begin
                    r_rp <= r_den;
                    r_rc <= r_rem;
                end
                OP_SUPD: begin
                    r_sp   <= r_sc;
                    r_sc   <= r_sp - r_prod;
                    r_num  <= r_rp;
                    r_den  <= r_rc;
                    r_rem  <= '0;
                    r_prod <= '0;
                    r_cnt  <= '0;
                end
                default: begin
                end
            endcase

            if (emit) begin
                r_out_valid <= 1'b1;
                r_has       <= (i_ctrl.op == OP_EMIT_OK);
                r_inverse   <= (i_ctrl.op == OP_EMIT_OK) ? inv_full[DATA_WIDTH-2:0] : '0;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid       = r_out_valid;
    assign o_inverse     = r_inverse;
    assign o_has_inverse = r_has;

    `MIE_ASSERT_IMPL(a_rem_below_divisor, i_ctrl.op == OP_DIV, r_rem < r_den)
    `MIE_ASSERT_IMPL(a_no_inverse_zero, r_out_valid && !r_has, r_inverse == '0)
    `MIE_ASSERT_NEXT(a_emit_shows, emit, r_out_valid)

endmodule

>>> src/modular_inverse_euclid_unit.sv
// Modular inverse unit: extended Euclid under microcode control.
//
// Input channel: i_valid / o_stall carry i_value and i_modulus (signed, magnitudes
// used). A transfer happens at a clock edge with i_valid high and o_stall low.
// Output channel: o_valid / i_stall carry o_inverse and o_has_inverse; a transfer
// happens at an edge with o_valid high and i_stall low.
// One item is worked at a time. Each Euclid step is one bit-serial division of
// DATA_WIDTH quotient bits plus three sequencer steps, and the next item is taken
// at the wait step once the result is written. A zero modulus is reported as no
// inverse from the zero check, without any division.
// The result sits in an output register; the sequencer waits at its emit step
// while that register is full and stalled, and returns to take the next item
// once the result is written.
// Reset (synchronous, active low) returns the sequencer to its wait step, empties
// the output register and clears the division counter; there is no clearing pass.
`include "modular_inverse_euclid_unit_defines.svh"

module modular_inverse_euclid_unit (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_stall,
    input  logic signed [mie_pkg::DATA_WIDTH-1:0] i_value,
    input  logic signed [mie_pkg::DATA_WIDTH-1:0] i_modulus,
    output logic                                  o_valid,
    input  logic                                  i_stall,
    output logic        [mie_pkg::DATA_WIDTH-2:0] o_inverse,
    output logic                                  o_has_inverse
);
    import mie_pkg::*;

    t_ctrl ctrl;
    t_stat stat;
    logic  in_xfer;

    // take input only at the wait step
    assign o_stall = (ctrl.op != OP_LOAD);
    assign in_xfer = i_valid && !o_stall;

    mie_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (stat),
        .o_ctrl  (ctrl)
    );

    mie_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctrl        (ctrl),
        .i_valid       (i_valid),
        .i_value       (i_value),
        .i_modulus     (i_modulus),
        .i_stall       (i_stall),
        .o_stat        (stat),
        .o_valid       (o_valid),
        .o_inverse     (o_inverse),
        .o_has_inverse (o_has_inverse)
    );

    `MIE_ASSERT_NEXT(a_busy_after_transfer, in_xfer, o_stall)

endmodule
